### rtl/core/mos_pkg.sv
`timescale 1ns / 1ps

package mos_pkg;

  // Field widths and default depth
  localparam int SAMPLE_W      = 32;
  localparam int RESULT_W      = 33;
  localparam int DEPTH_DEFAULT = 64;

  // Controller states
  typedef enum logic [0:0] {
    ST_INSERT,
    ST_SEEK
  } state_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                       insert;
    logic                       shift_down;
    logic signed [SAMPLE_W-1:0] sample;
  } cell_ctrl_t;

endpackage

### rtl/core/mos_in_if.sv
`timescale 1ns / 1ps

interface mos_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mos_pkg::SAMPLE_W-1:0] sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

### rtl/core/mos_out_if.sv
`timescale 1ns / 1ps

interface mos_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mos_pkg::RESULT_W-1:0] median_times_two;
  logic                                overflowed;

  modport source (output valid, output median_times_two, output overflowed, input ready);
  modport sink   (input valid, input median_times_two, input overflowed, output ready);
endinterface

### rtl/core/median_of_set.sv
`timescale 1ns / 1ps

// median_of_set: median of a set of signed Q16.16 values.
//
// samples: one value per transaction, last marks the final value of a set.
// result : one transaction per set, twice the median (33 bits, exact for an
//          even count) and a flag set when values beyond DEPTH were dropped.
//
// Within a set a sample is taken every cycle; each one is inserted into a
// chain of DEPTH compare-and-shift cells. After the final sample the chain
// shifts toward cell zero, one cell per cycle, until the lower middle value
// sits there; samples.ready stays low through this readout and until the
// result is registered, which waits while an earlier result is still
// stalled. The chain holds at most DEPTH values of a set.
//
// Reset empties the store and clears any pending result. If the receiver
// stalls, the result stays registered and the next set may already stream
// in; its readout then waits at the end until the stalled result is taken.
module median_of_set #(
  parameter int DEPTH = mos_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  mos_in_if.sink     samples,
  mos_out_if.source  result
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IDX1 = (DEPTH > 1) ? 1 : 0;

  mos_pkg::state_t   state, state_next;
  mos_pkg::cell_ctrl_t ctrl;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] seek, seek_next;
  logic          odd, odd_next;
  logic          dropped, dropped_next;
  logic          out_valid;
  logic          fire, ins, load;
  logic [CW-1:0] n_new;

  logic signed [mos_pkg::SAMPLE_W-1:0] cell_value [DEPTH];
  logic                                cell_shift [DEPTH];
  logic signed [mos_pkg::RESULT_W-1:0] twice;

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                                lshift;
    logic signed [mos_pkg::SAMPLE_W-1:0] lvalue;
    logic signed [mos_pkg::SAMPLE_W-1:0] rvalue;

    if (i == 0) begin : g_first
      assign lshift = 1'b0;
      assign lvalue = '0;
    end else begin : g_mid
      assign lshift = cell_shift[i-1];
      assign lvalue = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign rvalue = cell_value[i];
    end else begin : g_inner
      assign rvalue = cell_value[i+1];
    end

    mos_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .here_valid  (count > CW'(i)),
      .left_shift  (lshift),
      .left_value  (lvalue),
      .right_value (rvalue),
      .value       (cell_value[i]),
      .shift       (cell_shift[i])
    );
  end

  // Handshake and count arithmetic
  assign fire  = samples.valid && samples.ready;
  assign ins   = fire && (count < CW'(DEPTH));
  assign n_new = count + CW'(ins);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mos_pkg::ST_INSERT: begin
        if (fire && samples.last) begin
          state_next = mos_pkg::ST_SEEK;
        end
      end
      mos_pkg::ST_SEEK: begin
        if (load) begin
          state_next = mos_pkg::ST_INSERT;
        end
      end
      default: state_next = mos_pkg::ST_INSERT;
    endcase
  end

  // Controller outputs
  always_comb begin
    samples.ready   = 1'b0;
    ctrl.insert     = 1'b0;
    ctrl.shift_down = 1'b0;
    ctrl.sample     = samples.sample;
    load            = 1'b0;
    unique case (state)
      mos_pkg::ST_INSERT: begin
        samples.ready = 1'b1;
        // input is always open here, so a valid sample is a transaction
        ctrl.insert   = samples.valid && (count < CW'(DEPTH));
      end
      mos_pkg::ST_SEEK: begin
        ctrl.shift_down = (seek != '0);
        load            = (seek == '0) && (!out_valid || result.ready);
      end
      default: begin
        samples.ready = 1'b0;
      end
    endcase
  end

  // Bookkeeping next values
  always_comb begin
    count_next   = count;
    dropped_next = dropped;
    seek_next    = seek;
    odd_next     = odd;
    if (fire) begin
      count_next   = n_new;
      dropped_next = dropped || !ins;
      if (samples.last) begin
        seek_next = (n_new - CW'(1)) >> 1;
        odd_next  = n_new[0];
      end
    end
    if (ctrl.shift_down) begin
      seek_next = seek - CW'(1);
    end
    if (load) begin
      count_next   = '0;
      dropped_next = 1'b0;
    end
  end

  // Median from the bottom of the chain
  assign twice = odd ? {cell_value[0], 1'b0}
                     : {cell_value[0][mos_pkg::SAMPLE_W-1], cell_value[0]} +
                       {cell_value[IDX1][mos_pkg::SAMPLE_W-1], cell_value[IDX1]};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mos_pkg::ST_INSERT;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    seek <= seek_next;
    odd  <= odd_next;
    if (load) begin
      result.median_times_two <= twice;
      result.overflowed       <= dropped;
    end
  end

  assign result.valid = out_valid;

endmodule

### rtl/core/mos_cell.sv
`timescale 1ns / 1ps

// One compare-and-shift cell of the sorted chain.
module mos_cell (
  input  logic                                clk,
  input  mos_pkg::cell_ctrl_t                 ctrl,
  input  logic                                here_valid,
  input  logic                                left_shift,
  input  logic signed [mos_pkg::SAMPLE_W-1:0] left_value,
  input  logic signed [mos_pkg::SAMPLE_W-1:0] right_value,
  output logic signed [mos_pkg::SAMPLE_W-1:0] value,
  output logic                                shift
);

  // Held value moves up when the new sample sorts below it
  assign shift = here_valid && (value > ctrl.sample);

  // Insert: a moving or empty cell takes its left neighbor if that one moves,
  // else the sample. Readout: the whole chain moves toward cell zero.
  always_ff @(posedge clk) begin
    if (ctrl.shift_down) begin
      value <= right_value;
    end else if (ctrl.insert && (shift || !here_valid)) begin
      value <= left_shift ? left_value : ctrl.sample;
    end
  end

endmodule

### rtl/core/mos_checker.sv
`timescale 1ns / 1ps

// Port-level checks for median_of_set
module mos_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_last,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mos_pkg::RESULT_W-1:0] out_median,
  input logic                                out_overflowed
);

  // Final sample of a set starts readout, input closes
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still ready after final sample");

  // Streaming within a set never stalls
  a_stream_open: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_last |=> in_ready)
    else $error("input stalled within a set");

  // A new result only comes out of readout
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without readout");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(out_median) && $stable(out_overflowed))
    else $error("stalled result changed");

endmodule

bind median_of_set mos_checker u_mos_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samples.valid),
  .in_ready       (samples.ready),
  .in_last        (samples.last),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .out_median     (result.median_times_two),
  .out_overflowed (result.overflowed)
);

### tb/median_of_set_test.sv
`timescale 1ns / 1ps

module median_of_set_test;
  import mos_pkg::*;

  localparam int STORE_DEPTH  = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1400;
  localparam int TAIL_CYCLES  = STORE_DEPTH + 16;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] S_ONE = 32'sh0001_0000;  // 1.0 in Q16.16

  // Kinds of set content in the random part
  typedef enum int {
    FILL_WIDE,
    FILL_NARROW,
    FILL_EXTREME,
    FILL_FALLING
  } fill_kind_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] median_times_two;
    logic                       overflowed;
  } median_result_t;

  // Per-transaction note: a hand-written result overrides the predictor
  typedef struct packed {
    bit             typed;
    median_result_t value;
  } item_note_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    bit                         typed;
    logic signed [RESULT_W-1:0] median_times_two;
    logic                       overflowed;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  mos_in_if  samples_if ();
  mos_out_if result_if ();

  median_of_set #(
    .DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_if),
    .result (result_if)
  );

  // Predictor state: sorted store, fill level, drop flag
  logic signed [SAMPLE_W-1:0] held_sorted [STORE_DEPTH];
  int unsigned                held_n;
  logic                       held_dropped;

  median_result_t expected_medians [$];
  item_note_t     item_notes [$];

  int error_count;
  int send_idle_pct;
  int recv_idle_pct;

  // Directed sets; typed results only where they are obvious
  directed_row_t directed_rows [25] = '{
    // single zero right after reset
    '{32'sd0, 1'b1, 1'b1, 33'sd0, 1'b0},
    // single extremes
    '{S_MAX, 1'b1, 1'b1, 33'h0_FFFF_FFFE, 1'b0},
    '{S_MIN, 1'b1, 1'b1, 33'h1_0000_0000, 1'b0},
    // pair of opposite extremes
    '{S_MAX, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{S_MIN, 1'b1, 1'b1, 33'h1_FFFF_FFFF, 1'b0},
    // pair of maxima: largest positive result
    '{S_MAX, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{S_MAX, 1'b1, 1'b1, 33'h0_FFFF_FFFE, 1'b0},
    // three minima: most negative result
    '{S_MIN, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{S_MIN, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{S_MIN, 1'b1, 1'b1, 33'h1_0000_0000, 1'b0},
    // odd count, unsorted
    '{32'sd5, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{-32'sd3, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{32'sd1, 1'b1, 1'b0, 33'sd0, 1'b0},
    // equal values
    '{32'sd7, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{32'sd7, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{32'sd7, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{32'sd7, 1'b1, 1'b1, 33'sd14, 1'b0},
    // falling order, even count
    '{32'sd4, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{32'sd3, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{32'sd2, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{32'sd1, 1'b1, 1'b0, 33'sd0, 1'b0},
    // mixed signs around zero
    '{-32'sd1, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{32'sd1, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{S_ONE, 1'b0, 1'b0, 33'sd0, 1'b0},
    '{-S_ONE, 1'b1, 1'b0, 33'sd0, 1'b0}
  };

  // Clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Insert one value; on the marked one return twice the median and clear
  function automatic bit insert_and_median(input logic signed [SAMPLE_W-1:0] s,
                                           input logic l,
                                           output median_result_t r);
    int unsigned                pos;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    r = '0;
    if (held_n < STORE_DEPTH) begin
      pos = held_n;
      while (pos > 0 && held_sorted[pos-1] > s) begin
        held_sorted[pos] = held_sorted[pos-1];
        pos--;
      end
      held_sorted[pos] = s;
      held_n++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!l) return 1'b0;
    // for an odd count both indexes point at the middle cell
    lo = held_sorted[(held_n - 1) / 2];
    hi = held_sorted[held_n / 2];
    r.median_times_two = {lo[SAMPLE_W-1], lo} + {hi[SAMPLE_W-1], hi};
    r.overflowed       = held_dropped;
    held_n       = 0;
    held_dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic void report_error(input string what,
                                       input logic [RESULT_W-1:0] exp_val,
                                       input logic [RESULT_W-1:0] act_val);
    if (error_count < 10)
      $display("%0t: %s: expected %0d (0x%09h), got %0d (0x%09h)", $realtime, what,
               $signed(exp_val), exp_val, $signed(act_val), act_val);
    error_count++;
  endfunction

  // Monitor: result check first, then prediction of the accepted sample
  always @(posedge clk) begin
    median_result_t got;
    median_result_t want;
    median_result_t predicted;
    item_note_t     note;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        got.median_times_two = result_if.median_times_two;
        got.overflowed       = result_if.overflowed;
        if (expected_medians.size() == 0) begin
          report_error("result with none pending", '0, got.median_times_two);
        end else begin
          want = expected_medians.pop_front();
          if (got.median_times_two !== want.median_times_two)
            report_error("median_times_two", want.median_times_two, got.median_times_two);
          if (got.overflowed !== want.overflowed)
            report_error("overflowed", RESULT_W'(want.overflowed),
                         RESULT_W'(got.overflowed));
        end
      end
      if (samples_if.valid && samples_if.ready) begin
        note = item_notes.pop_front();
        if (insert_and_median(samples_if.sample, samples_if.last, predicted))
          expected_medians.push_back(note.typed ? note.value : predicted);
      end
    end
  end

  // Receiver: random back-pressure
  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one sample; returns at the falling edge after its transaction
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l,
                             input bit typed, input median_result_t typed_value);
    item_note_t note;
    note.typed = typed;
    note.value = typed_value;
    while ($urandom_range(99) < send_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_notes.push_back(note);
    samples_if.valid  <= 1'b1;
    samples_if.sample <= s;
    samples_if.last   <= l;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input fill_kind_t kind,
                                                             input int idx,
                                                             input logic [SAMPLE_W-1:0] base);
    case (kind)
      FILL_NARROW:  return $signed(32'($urandom_range(8))) - 32'sd4;
      FILL_FALLING: return base - 32'(idx * 16);
      FILL_EXTREME: begin
        case ($urandom_range(6))
          0:       return S_MIN;
          1:       return S_MAX;
          2:       return S_MIN + 32'sd1;
          3:       return S_MAX - 32'sd1;
          4:       return -32'sd1;
          5:       return 32'sd1;
          default: return 32'sd0;
        endcase
      end
      default:      return $urandom;
    endcase
  endfunction

  // Mostly short sets, some medium, a few past the store depth
  function automatic int pick_set_len(input int set_idx);
    int r;
    case (set_idx)
      0: return STORE_DEPTH;
      1: return STORE_DEPTH + 1;
      2: return STORE_DEPTH - 1;
      3: return STORE_DEPTH + 2;
      default: ;
    endcase
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 92) return $urandom_range(40, 9);
    return $urandom_range(STORE_DEPTH + 16, STORE_DEPTH - 8);
  endfunction

  task automatic wait_results_drained();
    while (expected_medians.size() != 0) @(negedge clk);
  endtask

  initial begin
    median_result_t typed_value;
    int             items_sent;
    int             set_idx;
    int             set_len;
    fill_kind_t     kind;
    logic [SAMPLE_W-1:0] base;

    error_count   = 0;
    send_idle_pct = 32;
    recv_idle_pct = 54;
    held_n        = 0;
    held_dropped  = 1'b0;
    rst               = 1'b1;
    samples_if.valid  = 1'b0;
    samples_if.sample = '0;
    samples_if.last   = 1'b0;
    result_if.ready   = 1'b0;

    // Synchronous reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    foreach (directed_rows[i]) begin
      typed_value.median_times_two = directed_rows[i].median_times_two;
      typed_value.overflowed       = directed_rows[i].overflowed;
      send_sample(directed_rows[i].sample, directed_rows[i].last,
                  directed_rows[i].typed, typed_value);
    end
    samples_if.valid <= 1'b0;
    wait_results_drained();

    // Random sets in three idling phases; the sender holds off between phases
    items_sent = 0;
    set_idx    = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (items_sent < (phase + 1) * RANDOM_ITEMS / 3) begin
        set_len = pick_set_len(set_idx);
        kind    = fill_kind_t'($urandom_range(3));
        base    = $urandom;
        for (int i = 0; i < set_len; i++)
          send_sample(pick_sample(kind, i, base), i == set_len - 1, 1'b0, '0);
        items_sent += set_len;
        set_idx++;
      end
      samples_if.valid <= 1'b0;
      wait_results_drained();
    end

    // Let any stray result surface
    repeat (TAIL_CYCLES) @(negedge clk);
    while (expected_medians.size() != 0) begin
      report_error("result never arrived", expected_medians[0].median_times_two, '0);
      void'(expected_medians.pop_front());
    end

    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
rtl/core/mos_pkg.sv
rtl/core/mos_in_if.sv
rtl/core/mos_out_if.sv
rtl/core/mos_cell.sv
rtl/core/median_of_set.sv
rtl/core/mos_checker.sv
tb/median_of_set_test.sv
